/* rtl/core/pvh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvh_pkg
// Shared constants, codes and types of the pack value histogram index.
// ----------------------------------------------------------------------------
package pvh_pkg;

	localparam int NUM_PACKS      = 64;
	localparam int WORDS_PER_PACK = 32;
	localparam int BINS           = 32 * WORDS_PER_PACK;
	localparam int DEPTH          = NUM_PACKS * WORDS_PER_PACK;
	localparam int ADDR_W         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SLOT_W         = (NUM_PACKS > 1) ? $clog2(NUM_PACKS) : 1;
	localparam int WORD_W         = (WORDS_PER_PACK > 1) ? $clog2(WORDS_PER_PACK) : 1;
	localparam int Q_W            = $clog2(BINS + 1);
	localparam int K_W            = $clog2(Q_W);
	localparam int CNT_W          = 11;
	localparam int PADDR_W        = 3;

	localparam logic [63:0] NULL_MARK  = 64'h8000_0000_0000_0001;
	localparam logic [63:0] SPAN_LIMIT = 64'h3FFF_FFFF_FFFF_FFFF;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_INSERT = 2'd1,
		OP_QUERY  = 2'd2,
		OP_COUNT  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ANS_NONE = 2'd0,
		ANS_SOME = 2'd1,
		ANS_ALL  = 2'd2
	} ans_t;

	typedef enum logic {
		REG_FIRST = 1'b0,
		REG_LAST  = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_CLEAR,
		ST_BIN,
		ST_DIV_WAIT,
		ST_INS_RD,
		ST_INS_WR,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_RESULT
	} state_t;

	// request to the ratio unit: floor(BINS * a / d)
	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] d;
	} div_req_t;

endpackage

/* rtl/core/pvh_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvh_ram
// Simple dual-port synchronous RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module pvh_ram #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 32,
	parameter int AW    = 11
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/pvh_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvh_div
// Iterative ratio unit: q = floor(BINS * a / d) for a < d, two steps per bit.
// ----------------------------------------------------------------------------
module pvh_div
	import pvh_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  div_req_t       req,
	output logic           done,
	output logic [Q_W-1:0] q
);

	localparam logic [Q_W-1:0] BINS_V = Q_W'(BINS);

	logic [63:0]    a_q, d_q, r_q, r_nx;
	logic [Q_W-1:0] q_q, q_nx;
	logic [K_W-1:0] k_q;
	logic           phase_q, busy_q, done_q;
	logic [63:0]    t;

	always_comb begin
		t    = '0;
		r_nx = r_q;
		q_nx = q_q;
		if (!phase_q) begin
			t    = {r_q[62:0], 1'b0};
			q_nx = {q_q[Q_W-2:0], 1'b0};
		end else begin
			t = r_q + (BINS_V[k_q] ? a_q : 64'd0);
		end
		if (t >= d_q) begin
			r_nx = t - d_q;
			q_nx = q_nx + Q_W'(1);
		end else begin
			r_nx = t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= 1'b0;
			k_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
				k_q     <= K_W'(Q_W - 1);
			end else if (busy_q) begin
				phase_q <= !phase_q;
				if (phase_q) begin
					if (k_q == '0) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						k_q <= k_q - K_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			d_q <= req.d;
			r_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			r_q <= r_nx;
			q_q <= q_nx;
		end
	end

	assign done = done_q;
	assign q    = q_q;

endmodule

/* rtl/core/pack_value_histogram_index_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pack_value_histogram_index_unit
// Per-pack 1024-bin presence bitmap: clear, insert, range query and count.
// ----------------------------------------------------------------------------
// One transaction is handled at a time; in_stall is low only while idle, and a
// finished result sits in the output register so the next transaction can be
// taken while it waits. A transaction may resolve at decode. Clear writes one
// zero word per cycle, 32 words; insert makes one bin lookup, exact or through
// the ratio unit, which finds the quotient one bit at a time, then reads and
// writes the bitmap word; a range query needs two bin lookups and then a read
// and a check per scanned word on the single read port; count reads and checks
// each word in the same way. Bitmaps live in a 2048 x 32 synchronous RAM.
// Per-slot valid flops replace a clearing pass: a slot that was never cleared
// reads as all ones, and only clear marks it valid, so there is no wait after
// reset.
// ----------------------------------------------------------------------------
module pack_value_histogram_index_unit
	import pvh_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// input transaction
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          opcode,
	input  logic [5:0]          pack_index,
	input  logic signed [63:0]  value_low,
	input  logic signed [63:0]  value_high,
	input  logic signed [63:0]  pack_minimum,
	input  logic signed [63:0]  pack_maximum,
	input  logic [10:0]         count_width,
	// result transaction
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          range_answer,
	output logic [CNT_W-1:0]    ones_count,
	// configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	// ---------------------------------------------------------------- config
	logic [5:0] first_q, last_q;
	reg_idx_t   cfg_idx;

	assign cfg_idx = reg_idx_t'(paddr[2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 6'd0;
			last_q  <= 6'd63;
		end else if (psel && penable && pwrite) begin
			unique case (cfg_idx)
				REG_FIRST: first_q <= pwdata[5:0];
				REG_LAST:  last_q  <= pwdata[5:0];
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_FIRST: prdata = {26'd0, first_q};
			REG_LAST:  prdata = {26'd0, last_q};
		endcase
	end

	// ---------------------------------------------------------------- helpers
	function automatic logic too_large(logic signed [63:0] lo, logic signed [63:0] hi);
		logic [63:0] diff;
		diff = $unsigned(hi) - $unsigned(lo);
		return (hi < lo) || (diff > SPAN_LIMIT);
	endfunction

	function automatic logic [5:0] popcount32(logic [31:0] w);
		logic [5:0] n;
		n = '0;
		for (int i = 0; i < 32; i++) begin
			n = n + 6'(w[i]);
		end
		return n;
	endfunction

	// ---------------------------------------------------------------- state
	state_t state_q, state_nx;

	op_t               op_q;
	logic [5:0]        pack_q;
	logic signed [63:0] lo_q, hi_q, min_q, max_q;
	logic [10:0]       width_q;

	logic [SLOT_W-1:0] slot_q;
	logic              exact_q, sel_hi_q;
	logic [63:0]       off_lo_q, off_hi_q, dvs_q;
	logic [Q_W-1:0]    b0_q;
	logic [WORD_W-1:0] word_q, wfirst_q, wlast_q;
	logic [4:0]        lobit_q, hibit_q;
	logic [1:0]        ans_q;
	logic [CNT_W-1:0]  acc_q;
	logic [NUM_PACKS-1:0] slot_valid_q;

	logic              out_valid_q;
	logic [1:0]        out_ans_q;
	logic [CNT_W-1:0]  out_cnt_q;

	// ---------------------------------------------------------------- decode
	logic [5:0]        rel;
	logic [SLOT_W-1:0] dec_slot;
	logic              dec_outside, dec_valid, tl_pack, tl_rng;
	logic [63:0]       span;
	logic              ins_skip;
	int                widthi, full_w, nwords;
	logic              partial;

	always_comb begin
		rel         = pack_q - first_q;
		dec_outside = (pack_q < first_q) || (pack_q > last_q) || (32'(rel) >= NUM_PACKS);
		dec_slot    = SLOT_W'(rel);
		dec_valid   = slot_valid_q[dec_slot];
		tl_pack     = too_large(min_q, max_q);
		tl_rng      = too_large(lo_q, hi_q);
		span        = $unsigned(max_q) - $unsigned(min_q);
		// an unwritten slot is all ones, so an insert cannot change it
		ins_skip    = dec_outside || ($unsigned(lo_q) == NULL_MARK) || tl_pack
		              || !(lo_q > min_q && lo_q < max_q) || !dec_valid;
		widthi      = int'(width_q);
		full_w      = (widthi >= BINS) ? WORDS_PER_PACK : (widthi >> 5);
		partial     = (full_w < WORDS_PER_PACK) && (width_q[4:0] != 5'd0);
		nwords      = full_w + int'(partial);
	end

	// ---------------------------------------------------------------- bin lookup
	div_req_t       div_req;
	logic           div_done;
	logic [Q_W-1:0] div_q;
	logic           bin_ready;
	logic [Q_W-1:0] bin_val;
	logic [63:0]    off_sel;

	assign off_sel   = sel_hi_q ? off_hi_q : off_lo_q;
	assign bin_ready = (state_q == ST_BIN && exact_q) || (state_q == ST_DIV_WAIT && div_done);
	assign bin_val   = exact_q ? off_sel[Q_W-1:0] : div_q;

	always_comb begin
		div_req.start = (state_q == ST_BIN) && !exact_q;
		div_req.a     = off_sel;
		div_req.d     = dvs_q;
	end

	pvh_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.q      (div_q)
	);

	// ---------------------------------------------------------------- memory
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_addr;
	logic [31:0]       mem_wdata, mem_rdata, masked;
	logic [31:0]       mask_lo, mask_hi;

	assign mem_addr = ADDR_W'(int'(slot_q) * WORDS_PER_PACK + int'(word_q));
	assign mask_lo  = (word_q == wfirst_q) ? (32'hFFFF_FFFF << lobit_q) : 32'hFFFF_FFFF;
	assign mask_hi  = (word_q == wlast_q) ? (32'hFFFF_FFFF >> (5'd31 - hibit_q))
	                                      : 32'hFFFF_FFFF;
	assign masked   = mem_rdata & mask_lo & mask_hi;

	pvh_ram #(
		.DEPTH (DEPTH),
		.WIDTH (32),
		.AW    (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_addr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_addr),
		.rdata (mem_rdata)
	);

	// memory controls per state
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_wdata = '0;
		unique case (state_q)
			ST_CLEAR: mem_we = 1'b1;
			ST_INS_RD, ST_SCAN_RD: mem_re = 1'b1;
			ST_INS_WR: begin
				mem_we    = 1'b1;
				mem_wdata = mem_rdata | (32'd1 << lobit_q);
			end
			default: begin
			end
		endcase
	end

	// ---------------------------------------------------------------- next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_nx = ST_DECODE;
			ST_DECODE: begin
				unique case (op_q)
					OP_CLEAR:  state_nx = dec_outside ? ST_RESULT : ST_CLEAR;
					OP_INSERT: state_nx = ins_skip ? ST_RESULT : ST_BIN;
					OP_QUERY: begin
						priority if (dec_outside || tl_pack || tl_rng) state_nx = ST_RESULT;
						else if (hi_q < min_q || lo_q > max_q)          state_nx = ST_RESULT;
						else if (hi_q >= max_q || lo_q <= min_q)        state_nx = ST_RESULT;
						else if (!dec_valid)                            state_nx = ST_RESULT;
						else                                            state_nx = ST_BIN;
					end
					OP_COUNT: state_nx = (dec_outside || !dec_valid || nwords == 0)
					                     ? ST_RESULT : ST_SCAN_RD;
				endcase
			end
			ST_CLEAR: if (word_q == WORD_W'(WORDS_PER_PACK - 1)) state_nx = ST_RESULT;
			ST_BIN, ST_DIV_WAIT: begin
				if (state_q == ST_BIN && !exact_q) state_nx = ST_DIV_WAIT;
				if (bin_ready) begin
					if (!sel_hi_q) begin
						if (op_q == OP_INSERT)
							state_nx = (32'(bin_val) >= BINS) ? ST_RESULT : ST_INS_RD;
						else
							state_nx = ST_BIN;
					end else begin
						state_nx = (32'(bin_val) >= BINS) ? ST_RESULT : ST_SCAN_RD;
					end
				end
			end
			ST_INS_RD:  state_nx = ST_INS_WR;
			ST_INS_WR:  state_nx = ST_RESULT;
			ST_SCAN_RD: state_nx = ST_SCAN_CHK;
			ST_SCAN_CHK: begin
				if (op_q == OP_QUERY && masked != '0) state_nx = ST_RESULT;
				else if (word_q == wlast_q)           state_nx = ST_RESULT;
				else                                  state_nx = ST_SCAN_RD;
			end
			ST_RESULT: if (!out_valid_q || !out_stall) state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			slot_valid_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			// clear marks the slot as written once its last word goes out
			if (state_q == ST_CLEAR && word_q == WORD_W'(WORDS_PER_PACK - 1))
				slot_valid_q[slot_q] <= 1'b1;
			if (state_q == ST_RESULT && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// ---------------------------------------------------------------- datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					op_q    <= op_t'(opcode);
					pack_q  <= pack_index;
					lo_q    <= value_low;
					hi_q    <= value_high;
					min_q   <= pack_minimum;
					max_q   <= pack_maximum;
					width_q <= count_width;
					ans_q   <= ANS_NONE;
					acc_q   <= '0;
				end
			end
			ST_DECODE: begin
				slot_q   <= dec_slot;
				exact_q  <= span <= (64'(BINS) + 64'd1);
				off_lo_q <= $unsigned(lo_q) - $unsigned(min_q) - 64'd1;
				off_hi_q <= $unsigned(hi_q) - $unsigned(min_q) - 64'd1;
				dvs_q    <= span - 64'd1;
				sel_hi_q <= 1'b0;
				word_q   <= '0;
				unique case (op_q)
					OP_QUERY: begin
						priority if (dec_outside || tl_pack || tl_rng) ans_q <= ANS_SOME;
						else if (hi_q < min_q || lo_q > max_q)          ans_q <= ANS_NONE;
						else if (hi_q >= max_q && lo_q <= min_q)        ans_q <= ANS_ALL;
						else if (hi_q >= max_q || lo_q <= min_q)        ans_q <= ANS_SOME;
						else if (!dec_valid)                            ans_q <= ANS_SOME;
						else                                            ans_q <= ANS_NONE;
					end
					OP_COUNT: begin
						wfirst_q <= '0;
						wlast_q  <= WORD_W'(nwords - 1);
						lobit_q  <= 5'd0;
						hibit_q  <= partial ? (width_q[4:0] - 5'd1) : 5'd31;
						// an unwritten slot is all ones
						if (!dec_outside && !dec_valid)
							acc_q <= CNT_W'((widthi >= BINS) ? BINS : widthi);
					end
					default: begin
					end
				endcase
			end
			ST_CLEAR: word_q <= word_q + WORD_W'(1);
			ST_BIN, ST_DIV_WAIT: begin
				if (bin_ready) begin
					if (!sel_hi_q) begin
						b0_q     <= bin_val;
						sel_hi_q <= 1'b1;
						word_q   <= WORD_W'(bin_val >> 5);
						lobit_q  <= bin_val[4:0];
					end else begin
						wfirst_q <= WORD_W'(b0_q >> 5);
						word_q   <= WORD_W'(b0_q >> 5);
						lobit_q  <= b0_q[4:0];
						wlast_q  <= WORD_W'(bin_val >> 5);
						hibit_q  <= bin_val[4:0];
						if (32'(bin_val) >= BINS) ans_q <= ANS_SOME;
					end
				end
			end
			ST_SCAN_CHK: begin
				if (op_q == OP_QUERY) begin
					if (masked != '0) ans_q <= ANS_SOME;
				end else begin
					acc_q <= acc_q + CNT_W'(popcount32(masked));
				end
				word_q <= word_q + WORD_W'(1);
			end
			ST_RESULT: begin
				if (!out_valid_q || !out_stall) begin
					out_ans_q <= (op_q == OP_QUERY) ? ans_q : ANS_NONE;
					out_cnt_q <= (op_q == OP_COUNT) ? acc_q : '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign range_answer = out_ans_q;
	assign ones_count   = out_cnt_q;

	// ---------------------------------------------------------------- checks
	// a taken transaction closes the input side on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accept");

	// memory is only touched while a transaction is in flight
	a_mem_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we || mem_re) |-> (state_q != ST_IDLE && state_q != ST_RESULT))
		else $error("memory access outside a transaction");

	// a new result only comes out of the result state
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_RESULT)
		else $error("result without result state");

	// the ratio unit reports done only while it is awaited
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV_WAIT)
		else $error("ratio unit done while not awaited");

endmodule

/* sim/tb_pack_value_histogram_index_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pack_value_histogram_index_unit
// Self-checking bench: directed rows, then random transactions under several
// window settings, each result checked by a bitmap predictor or a fixed row.
// ----------------------------------------------------------------------------
module tb_pack_value_histogram_index_unit;
	import pvh_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int RAND_ITEMS  = 1130;
	localparam int N_DIR       = 20;
	localparam int N_WIN       = 6;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         opcode = OP_CLEAR;
	logic [5:0]         pack_index = '0;
	logic signed [63:0] value_low = '0;
	logic signed [63:0] value_high = '0;
	logic signed [63:0] pack_minimum = '0;
	logic signed [63:0] pack_maximum = '0;
	logic [10:0]        count_width = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         range_answer;
	logic [CNT_W-1:0]   ones_count;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	pack_value_histogram_index_unit dut (.*);

	always #10 clk = ~clk;

	// one histogram request as the table and the generator describe it
	typedef struct packed {
		logic [1:0]  op;
		logic [5:0]  pack;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mn;
		logic [63:0] mx;
		logic [10:0] width;
		logic        fixed;     // expected values below are typed in
		logic [1:0]  ans;
		logic [10:0] cnt;
	} hist_req_t;

	typedef struct packed {
		logic [1:0]  ans;
		logic [10:0] cnt;
	} hist_res_t;

	// predictor state: its own copy of the bitmaps and the window
	logic [31:0] presence_words [DEPTH];
	logic [5:0]  win_first = 6'd0;
	logic [5:0]  win_last  = 6'd63;

	hist_res_t pending_results [$];
	int        errors = 0;
	int        cycles = 0;

	// word offset of the pack's slot, -1 when outside the window
	function automatic int slot_of(logic [5:0] pk);
		if (pk < win_first || pk > win_last)
			return -1;
		if (int'(pk - win_first) >= NUM_PACKS)
			return -1;
		return int'(pk - win_first) * WORDS_PER_PACK;
	endfunction

	function automatic bit span_too_wide(logic signed [63:0] a, logic signed [63:0] b);
		logic [63:0] d;
		if (b < a)
			return 1'b1;
		d = b - a;
		return d > SPAN_LIMIT;
	endfunction

	// exact mode: one value per bin; interval mode: exact scaled ratio
	function automatic int unsigned bin_index(logic [63:0] v, logic [63:0] mn,
			logic [63:0] mx);
		logic [63:0]  span;
		logic [63:0]  off;
		logic [127:0] q;
		span = mx - mn;
		off  = v - mn - 64'd1;
		if (span <= 64'(BINS + 1))
			return int'(off[31:0]);
		q = ({64'd0, off} * 128'(BINS)) / {64'd0, span - 64'd1};
		return int'(q[31:0]);
	endfunction

	function automatic hist_res_t predict_outcome(hist_req_t r);
		hist_res_t          res;
		int                 base;
		int unsigned        b0, b1, b, full, rest, total;
		logic signed [63:0] lo, hi, mn, mx;
		lo = r.lo; hi = r.hi; mn = r.mn; mx = r.mx;
		base = slot_of(r.pack);
		res.ans = ANS_NONE;
		total = 0;
		case (op_t'(r.op))
			OP_CLEAR: begin
				if (base >= 0)
					for (int i = 0; i < WORDS_PER_PACK; i++) presence_words[base + i] = '0;
			end
			OP_INSERT: begin
				if (base >= 0 && r.lo != NULL_MARK && !span_too_wide(mn, mx)
						&& lo > mn && lo < mx) begin
					b = bin_index(r.lo, r.mn, r.mx);
					if (b < BINS)
						presence_words[base + b / 32][b % 32] = 1'b1;
				end
			end
			OP_QUERY: begin
				if (base < 0 || span_too_wide(mn, mx) || span_too_wide(lo, hi))
					res.ans = ANS_SOME;
				else if (hi < mn || lo > mx)
					res.ans = ANS_NONE;
				else if (hi >= mx && lo <= mn)
					res.ans = ANS_ALL;
				else if (hi >= mx || lo <= mn)
					res.ans = ANS_SOME;
				else begin
					b0 = bin_index(r.lo, r.mn, r.mx);
					b1 = bin_index(r.hi, r.mn, r.mx);
					if (b1 >= BINS)
						res.ans = ANS_SOME;
					else
						for (b = b0; b <= b1; b++)
							if (presence_words[base + b / 32][b % 32]) begin
								res.ans = ANS_SOME;
								break;
							end
				end
			end
			default: begin
				if (base >= 0) begin
					full = (r.width >= BINS) ? WORDS_PER_PACK : r.width / 32;
					rest = r.width % 32;
					for (int i = 0; i < full; i++)
						total += $countones(presence_words[base + i]);
					if (full < WORDS_PER_PACK && rest > 0)
						total += $countones(presence_words[base + full]
							& ~(32'hFFFF_FFFF << rest));
				end
			end
		endcase
		res.cnt = total[10:0];
		return res;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// random request: mostly well-formed values inside a sensible span
	function automatic hist_req_t random_request();
		hist_req_t   r;
		logic [63:0] span, a, b, t;
		int          pick;
		r = '0;
		pick = $urandom_range(0, 99);
		r.op = (pick < 5) ? OP_CLEAR : (pick < 50) ? OP_INSERT : (pick < 82) ? OP_QUERY : OP_COUNT;
		r.pack = ($urandom_range(0, 9) < 7) ? win_first + 6'($urandom_range(0, 3))
			: 6'($urandom_range(0, 63));
		r.width = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 2047))
			: 11'($urandom_range(0, 1024));
		pick = $urandom_range(0, 99);
		if (pick < 45)
			span = 64'($urandom_range(2, BINS + 1));
		else if (pick < 85)
			span = rand64() >> $urandom_range(2, 60);
		else if (pick < 92)
			span = SPAN_LIMIT - 64'($urandom_range(0, 1));
		else
			span = rand64();
		if (span < 2)
			span = 2;
		r.mn = ($urandom_range(0, 3) == 0) ? rand64() : 64'($signed($urandom_range(0, 4000)) - 2000);
		r.mx = r.mn + span;
		if ($urandom_range(0, 19) == 0)
			r.mx = rand64();
		a = r.mn + 64'd1 + rand64() % (span - 64'd1);
		b = r.mn + 64'd1 + rand64() % (span - 64'd1);
		if ($signed(a) > $signed(b)) begin
			t = a; a = b; b = t;
		end
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			r.lo = a;
			r.hi = ($urandom_range(0, 1) == 0) ? a + 64'($urandom_range(0, 40)) : b;
		end else if (pick < 80) begin
			r.lo = r.mn - 64'($urandom_range(0, 5));
			r.hi = b;
		end else if (pick < 88) begin
			r.lo = a;
			r.hi = r.mx + 64'($urandom_range(0, 5));
		end else if (pick < 93) begin
			r.lo = NULL_MARK;
			r.hi = rand64();
		end else begin
			r.lo = rand64();
			r.hi = rand64();
		end
		return r;
	endfunction

	// sender side: hold the transaction until it is taken
	task automatic send_request(hist_req_t r);
		hist_res_t res;
		in_valid     <= 1'b1;
		opcode       <= r.op;
		pack_index   <= r.pack;
		value_low    <= r.lo;
		value_high   <= r.hi;
		pack_minimum <= r.mn;
		pack_maximum <= r.mx;
		count_width  <= r.width;
		do @(posedge clk); while (in_stall);
		res = predict_outcome(r);
		if (r.fixed) begin
			res.ans = r.ans;
			res.cnt = r.cnt;
		end
		pending_results.push_back(res);
	endtask

	task automatic apb_write(reg_idx_t idx, logic [5:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(4 * int'(idx));
		pwdata  <= 32'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_FIRST)
			win_first = val;
		else
			win_last = val;
	endtask

	// result checker: compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result ans=%0d cnt=%0d", $time, range_answer, ones_count);
				errors++;
			end else begin
				if (range_answer !== pending_results[0].ans) begin
					$display("%0t range_answer expected %0d actual %0d", $time,
						pending_results[0].ans, range_answer);
					errors++;
				end
				if (ones_count !== pending_results[0].cnt) begin
					$display("%0t ones_count expected %0d actual %0d", $time,
						pending_results[0].cnt, ones_count);
					errors++;
				end
				void'(pending_results.pop_front());
			end
		end
	end

	// receiver stall pattern: random stalls at a rate redrawn from 0, 30 and 75 percent
	int stall_pct = 0;
	always @(posedge clk) begin
		if (cycles % 64 == 0)
			case ($urandom_range(0, 3))
				0, 1: stall_pct <= 0;
				2: stall_pct <= 30;
				default: stall_pct <= 75;
			endcase
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[pack_value_histogram_index_unit] ERROR");
			$finish;
		end
	end

	hist_req_t   dir_rows [N_DIR];
	logic [11:0] win_sets [N_WIN];

	initial begin
		int burst;
		int per_phase;
		// directed rows under the reset window; fixed rows carry their result
		dir_rows = '{
			'{OP_COUNT,  6'd0,  64'd0, 64'd0, 64'd0, 64'd0, 11'd1024, 1'b1, ANS_NONE, 11'd1024},
			'{OP_COUNT,  6'd0,  64'd0, 64'd0, 64'd0, 64'd0, 11'd0,    1'b1, ANS_NONE, 11'd0},
			'{OP_COUNT,  6'd63, 64'd0, 64'd0, 64'd0, 64'd0, 11'd5,    1'b1, ANS_NONE, 11'd5},
			'{OP_CLEAR,  6'd0,  64'd0, 64'd0, 64'd0, 64'd0, 11'd0,    1'b1, ANS_NONE, 11'd0},
			'{OP_COUNT,  6'd0,  64'd0, 64'd0, 64'd0, 64'd0, 11'd2047, 1'b1, ANS_NONE, 11'd0},
			'{OP_INSERT, 6'd0,  64'd5, 64'd0, 64'd0, 64'd100, 11'd0,  1'b1, ANS_NONE, 11'd0},
			'{OP_COUNT,  6'd0,  64'd0, 64'd0, 64'd0, 64'd0, 11'd1024, 1'b1, ANS_NONE, 11'd1},
			'{OP_QUERY,  6'd0,  64'd5, 64'd5, 64'd0, 64'd100, 11'd0,  1'b0, ANS_NONE, 11'd0},
			'{OP_QUERY,  6'd0,  64'd6, 64'd50, 64'd0, 64'd100, 11'd0, 1'b0, ANS_NONE, 11'd0},
			'{OP_QUERY,  6'd0,  -64'sd10, -64'sd1, 64'd0, 64'd100, 11'd0, 1'b1, ANS_NONE, 11'd0},
			'{OP_QUERY,  6'd0,  -64'sd10, 64'd200, 64'd0, 64'd100, 11'd0, 1'b1, ANS_ALL, 11'd0},
			'{OP_QUERY,  6'd0,  64'd0, 64'd50, 64'd0, 64'd100, 11'd0, 1'b1, ANS_SOME, 11'd0},
			// null value lies inside this pack's extremes but is never stored
			'{OP_INSERT, 6'd0,  NULL_MARK, 64'd0, 64'h8000_0000_0000_0000,
				64'h8000_0000_0000_0010, 11'd0, 1'b1, ANS_NONE, 11'd0},
			// pack extremes reversed, then query range reversed
			'{OP_QUERY,  6'd0,  64'd1, 64'd2, 64'd100, 64'd0, 11'd0, 1'b1, ANS_SOME, 11'd0},
			'{OP_QUERY,  6'd0,  64'd9, 64'd3, 64'd0, 64'd100, 11'd0, 1'b1, ANS_SOME, 11'd0},
			// span above the limit: insert dropped
			'{OP_INSERT, 6'd0,  64'd7, 64'd0, 64'hC000_0000_0000_0000,
				64'h4000_0000_0000_0000, 11'd0, 1'b1, ANS_NONE, 11'd0},
			// interval mode bin
			'{OP_INSERT, 6'd0,  64'd999_999, 64'd0, 64'd0, 64'd1_000_000, 11'd0,
				1'b0, ANS_NONE, 11'd0},
			// value at the pack maximum is dropped
			'{OP_INSERT, 6'd0,  64'h7FFF_FFFF_FFFF_FFFF, 64'd0, 64'h7FFF_FFFF_FFFF_FF00,
				64'h7FFF_FFFF_FFFF_FFFF, 11'd0, 1'b1, ANS_NONE, 11'd0},
			'{OP_COUNT,  6'd0,  64'd0, 64'd0, 64'd0, 64'd0, 11'd1024, 1'b1, ANS_NONE, 11'd2},
			'{OP_COUNT,  6'd0,  64'd0, 64'd0, 64'd0, 64'd0, 11'd1000, 1'b0, ANS_NONE, 11'd0}
		};
		// window settings {first, last}, extremes and an empty window included
		win_sets = '{{6'd0, 6'd0}, {6'd63, 6'd63}, {6'd10, 6'd40}, {6'd40, 6'd10},
			{6'd60, 6'd63}, {6'd0, 6'd63}};
		for (int i = 0; i < DEPTH; i++)
			presence_words[i] = 32'hFFFF_FFFF;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_request(dir_rows[i]);
		in_valid <= 1'b0;

		per_phase = RAND_ITEMS / N_WIN;
		for (int ph = 0; ph < N_WIN; ph++) begin
			// pause until the block is idle, then move the window
			in_valid <= 1'b0;
			wait (pending_results.size() == 0);
			repeat (5) @(posedge clk);
			apb_write(REG_FIRST, win_sets[ph][11:6]);
			apb_write(REG_LAST, win_sets[ph][5:0]);
			for (int n = 0; n < per_phase; ) begin
				burst = $urandom_range(1, 24);
				for (int k = 0; k < burst && n < per_phase; k++, n++)
					send_request(random_request());
				if ($urandom_range(0, 2) != 0) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 20)) @(posedge clk);
				end
			end
		end
		in_valid <= 1'b0;

		wait (pending_results.size() == 0);
		repeat (150) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("[pack_value_histogram_index_unit] OK");
		else
			$display("[pack_value_histogram_index_unit] ERROR");
		$finish;
	end

endmodule

/* files.f */
rtl/core/pvh_pkg.sv
rtl/core/pvh_ram.sv
rtl/core/pvh_div.sv
rtl/core/pack_value_histogram_index_unit.sv
sim/tb_pack_value_histogram_index_unit.sv
